// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/lmpt_pkg.sv =====
`default_nettype none

package lmpt_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 24;
  localparam int INV_BITS      = 31;
  localparam int NUM_ROWS      = 6;
  localparam int NUM_COL       = 7;
  localparam int NUM_COEF      = NUM_ROWS * NUM_COL;
  localparam int IDX_BITS      = 6;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = CFG_ADDR_BITS - 2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_TRACK = 1'b1;

  localparam logic [REG_IDX_BITS-1:0] REG_INV_V0BYC = '0;

  typedef struct packed {
    logic                        action;
    logic [IDX_BITS-1:0]         coef_index;
    logic signed [WORD_BITS-1:0] coef_value;
    logic signed [WORD_BITS-1:0] x_in;
    logic signed [WORD_BITS-1:0] px_in;
    logic signed [WORD_BITS-1:0] y_in;
    logic signed [WORD_BITS-1:0] py_in;
    logic signed [WORD_BITS-1:0] ct_in;
    logic signed [WORD_BITS-1:0] de_in;
    logic                        lost_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] x_out;
    logic signed [WORD_BITS-1:0] px_out;
    logic signed [WORD_BITS-1:0] y_out;
    logic signed [WORD_BITS-1:0] py_out;
    logic signed [WORD_BITS-1:0] ct_out;
    logic signed [WORD_BITS-1:0] de_out;
    logic                        lost_out;
  } out_item_t;

  // Particle coordinates carried down the pipeline.
  typedef struct packed {
    logic signed [WORD_BITS-1:0] x;
    logic signed [WORD_BITS-1:0] px;
    logic signed [WORD_BITS-1:0] y;
    logic signed [WORD_BITS-1:0] py;
    logic signed [WORD_BITS-1:0] ct;
    logic signed [WORD_BITS-1:0] de;
    logic                        lost;
  } trk_t;

endpackage

`default_nettype wire

// ===== rtl/core/linear_map_particle_tracker.sv =====
`default_nettype none

`include "assert_macros.svh"

// Linear map particle tracker: applies a 6x7 affine transfer map to particle coordinates
// (signed Q8.24, FRAC_BITS fractional bits). A request with action = load writes one map
// coefficient at the moment it is accepted and gives no result; a slot above 41 is dropped.
// A request with action = track gives exactly one result, in order: a lost particle comes
// out unchanged, otherwise t = 1 - de*inv_v0byc and the slopes px*t, py*t feed the x and y
// rows while the other rows use px and py. All products are rounded half up and sums
// saturate to 32 bits. Rate: one request per cycle while in_stall is low, loads and tracks
// mixed freely. A track takes one register stage per step: capture, multiply (de*inv_v0byc),
// round, form t, multiply by t, round and saturate, multiply by slope coefficients, round,
// pair, add and saturate. Each stage holds its own valid bit and advances whenever the stage
// after it is empty or moving, so bubbles close up and the input keeps taking requests while
// a finished result waits at the output register; in_stall rises only when all ten stages
// are full and out_stall is high. A new map takes effect for every track request accepted
// after the load. The user must write the inv_v0byc register (APB, byte address 0, reset
// 1.0) only while the block is idle; it does not enforce this. pready is always high.
module linear_map_particle_tracker #(
  parameter int FRAC_BITS = lmpt_pkg::FRAC_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  lmpt_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output lmpt_pkg::out_item_t                   out_data,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [lmpt_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  wire  [lmpt_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [lmpt_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);

  import lmpt_pkg::*;

  localparam int W        = WORD_BITS;
  localparam int PW       = 2 * W;
  localparam int RND_BITS = PW - FRAC_BITS;
  localparam int TW       = ((RND_BITS > FRAC_BITS + 1) ? RND_BITS : FRAC_BITS + 1) + 1;
  localparam int SUM_BITS = ((RND_BITS > W) ? RND_BITS : W) + 3;
  localparam int SAT_BITS = (SUM_BITS > TW) ? SUM_BITS : TW;
  localparam int NSTG     = 10;

  localparam logic signed [PW-1:0]       HALF    = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [TW-1:0]       ONE_T   = TW'(1) << FRAC_BITS;
  localparam logic [INV_BITS-1:0]        INV_ONE = INV_BITS'(1) << FRAC_BITS;
  localparam logic signed [SAT_BITS-1:0] SAT_MAX = {{(SAT_BITS-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SAT_BITS-1:0] SAT_MIN = ~SAT_MAX;

  function automatic logic signed [RND_BITS-1:0] rnd_q(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + HALF;
    return s[PW-1:FRAC_BITS];
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [SAT_BITS-1:0] v);
    logic signed [W-1:0] r;
    if (v > SAT_MAX) begin
      r = {1'b0, {(W-1){1'b1}}};
    end else if (v < SAT_MIN) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // Slope terms of the x and y rows are formed late, after t is known.
  function automatic logic is_late(input int r, input int k);
    return ((r == 0) || (r == 2)) && ((k == 1) || (k == 3));
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [INV_BITS-1:0]     inv_r;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= INV_ONE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INV_V0BYC: inv_r <= pwdata[INV_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INV_V0BYC: prdata = CFG_DATA_BITS'(inv_r);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic [NSTG:1] vld_r;
  logic [NSTG:1] rdy;
  logic          in_acc;
  logic          load_acc;

  // A stage may take new data when it is empty or its content moves on.
  always_comb begin
    rdy[NSTG] = !vld_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_data.action == ACT_LOAD);
  assign out_valid = vld_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      // Loads are consumed on acceptance; only tracks enter the pipeline.
      if (rdy[1]) begin
        vld_r[1] <= in_valid && (in_data.action == ACT_TRACK);
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- map coefficients
  // Written at acceptance, read by the track request in stage 1. A stage-1 item
  // that moves at the same edge samples the old map, as it came first.
  logic signed [W-1:0] coef_r [NUM_COEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (load_acc && (in_data.coef_index < IDX_BITS'(NUM_COEF))) begin
      coef_r[in_data.coef_index] <= in_data.coef_value;
    end
  end

  // ---------------------------------------------------------------- data path
  trk_t                  trk_r [1:NSTG-1];
  logic signed [W-1:0]   v1 [6];
  logic signed [W-1:0]   inv_s;

  logic signed [PW-1:0]       pr2_r  [NUM_ROWS][6];
  logic signed [PW-1:0]       pde2_r;
  logic signed [W-1:0]        c0_r   [2:3][NUM_ROWS];
  logic signed [W-1:0]        cl_r   [2:6][4];
  logic signed [RND_BITS-1:0] rnd3_r [NUM_ROWS][6];
  logic signed [RND_BITS-1:0] qde3_r;
  logic signed [W-1:0]        t4_r;
  logic signed [SUM_BITS-1:0] sum4_r [NUM_ROWS][4];
  logic signed [PW-1:0]       sxp5_r;
  logic signed [PW-1:0]       syp5_r;
  logic signed [SUM_BITS-1:0] sum5_r [NUM_ROWS][2];
  logic signed [W-1:0]        sx6_r;
  logic signed [W-1:0]        sy6_r;
  logic signed [SUM_BITS-1:0] sum6_r [NUM_ROWS];
  logic signed [PW-1:0]       lp7_r  [4];
  logic signed [SUM_BITS-1:0] sum7_r [NUM_ROWS];
  logic signed [RND_BITS-1:0] lr8_r  [4];
  logic signed [SUM_BITS-1:0] sum8_r [NUM_ROWS];
  logic signed [SUM_BITS-1:0] ls9_r  [2];
  logic signed [SUM_BITS-1:0] sum9_r [NUM_ROWS];
  out_item_t                  out_r;
  out_item_t                  out_nxt;
  logic signed [W-1:0]        res    [NUM_ROWS];

  always_comb begin
    v1[0] = trk_r[1].x;
    v1[1] = trk_r[1].px;
    v1[2] = trk_r[1].y;
    v1[3] = trk_r[1].py;
    v1[4] = trk_r[1].ct;
    v1[5] = trk_r[1].de;
  end

  assign inv_s = {{(W-INV_BITS){1'b0}}, inv_r};

  // Stage 1: capture the particle, then carry it alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      trk_r[1] <= '{x: in_data.x_in, px: in_data.px_in, y: in_data.y_in,
                    py: in_data.py_in, ct: in_data.ct_in, de: in_data.de_in,
                    lost: in_data.lost_in};
    end
    for (int k = 2; k <= NSTG - 1; k++) begin
      if (rdy[k]) begin
        trk_r[k] <= trk_r[k-1];
      end
    end
  end

  // Stage 2: all products that do not depend on t.
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      pde2_r <= v1[5] * inv_s;
      for (int r = 0; r < NUM_ROWS; r++) begin
        c0_r[2][r] <= coef_r[r*NUM_COL];
        for (int k = 0; k < 6; k++) begin
          if (is_late(r, k)) begin
            pr2_r[r][k] <= '0;
          end else begin
            pr2_r[r][k] <= coef_r[r*NUM_COL+k+1] * v1[k];
          end
        end
      end
    end
  end

  // Slope coefficients of the x and y rows, taken in stage 2 and carried to stage 6.
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      cl_r[2][0] <= coef_r[0*NUM_COL+2];
      cl_r[2][1] <= coef_r[0*NUM_COL+4];
      cl_r[2][2] <= coef_r[2*NUM_COL+2];
      cl_r[2][3] <= coef_r[2*NUM_COL+4];
    end
    for (int k = 3; k <= 6; k++) begin
      if (rdy[k]) begin
        cl_r[k] <= cl_r[k-1];
      end
    end
  end

  // Stage 3: round.
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      qde3_r  <= rnd_q(pde2_r);
      c0_r[3] <= c0_r[2];
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int k = 0; k < 6; k++) begin
          rnd3_r[r][k] <= rnd_q(pr2_r[r][k]);
        end
      end
    end
  end

  // Stage 4: form t, first level of the row adder tree.
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      t4_r <= sat_w(SAT_BITS'(ONE_T - TW'(qde3_r)));
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum4_r[r][0] <= SUM_BITS'(c0_r[3][r]) + SUM_BITS'(rnd3_r[r][0]);
        sum4_r[r][1] <= SUM_BITS'(rnd3_r[r][1]) + SUM_BITS'(rnd3_r[r][2]);
        sum4_r[r][2] <= SUM_BITS'(rnd3_r[r][3]) + SUM_BITS'(rnd3_r[r][4]);
        sum4_r[r][3] <= SUM_BITS'(rnd3_r[r][5]);
      end
    end
  end

  // Stage 5: slope products.
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      sxp5_r <= trk_r[4].px * t4_r;
      syp5_r <= trk_r[4].py * t4_r;
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum5_r[r][0] <= sum4_r[r][0] + sum4_r[r][1];
        sum5_r[r][1] <= sum4_r[r][2] + sum4_r[r][3];
      end
    end
  end

  // Stage 6: round and saturate the slopes.
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      sx6_r <= sat_w(SAT_BITS'(rnd_q(sxp5_r)));
      sy6_r <= sat_w(SAT_BITS'(rnd_q(syp5_r)));
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum6_r[r] <= sum5_r[r][0] + sum5_r[r][1];
      end
    end
  end

  // Stage 7: slope terms of the x and y rows.
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      lp7_r[0] <= cl_r[6][0] * sx6_r;
      lp7_r[1] <= cl_r[6][1] * sy6_r;
      lp7_r[2] <= cl_r[6][2] * sx6_r;
      lp7_r[3] <= cl_r[6][3] * sy6_r;
      sum7_r   <= sum6_r;
    end
  end

  // Stage 8: round the slope terms.
  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int j = 0; j < 4; j++) begin
        lr8_r[j] <= rnd_q(lp7_r[j]);
      end
      sum8_r <= sum7_r;
    end
  end

  // Stage 9: pair the slope terms per row.
  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      ls9_r[0] <= SUM_BITS'(lr8_r[0]) + SUM_BITS'(lr8_r[1]);
      ls9_r[1] <= SUM_BITS'(lr8_r[2]) + SUM_BITS'(lr8_r[3]);
      sum9_r   <= sum8_r;
    end
  end

  // Stage 10: final sum, saturate, pass lost particles unchanged.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (r == 0) begin
        res[r] = sat_w(SAT_BITS'(sum9_r[r] + ls9_r[0]));
      end else if (r == 2) begin
        res[r] = sat_w(SAT_BITS'(sum9_r[r] + ls9_r[1]));
      end else begin
        res[r] = sat_w(SAT_BITS'(sum9_r[r]));
      end
    end
    if (trk_r[NSTG-1].lost) begin
      out_nxt.x_out  = trk_r[NSTG-1].x;
      out_nxt.px_out = trk_r[NSTG-1].px;
      out_nxt.y_out  = trk_r[NSTG-1].y;
      out_nxt.py_out = trk_r[NSTG-1].py;
      out_nxt.ct_out = trk_r[NSTG-1].ct;
      out_nxt.de_out = trk_r[NSTG-1].de;
    end else begin
      out_nxt.x_out  = res[0];
      out_nxt.px_out = res[1];
      out_nxt.y_out  = res[2];
      out_nxt.py_out = res[3];
      out_nxt.ct_out = res[4];
      out_nxt.de_out = res[5];
    end
    out_nxt.lost_out = trk_r[NSTG-1].lost;
  end

  // Hold the result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------------------------------------------------------- checks
  `ASSERT_CLK(a_load_no_entry,
    (in_valid && !in_stall && (in_data.action == ACT_LOAD)) |=> !vld_r[1],
    "load request entered the pipeline")
  `ASSERT_CLK(a_stall_only_full,
    in_stall |-> ((&vld_r) && out_stall),
    "input stalled with a bubble in the pipeline")
  `ASSERT_CLK(a_out_from_stage9,
    $rose(out_valid) |-> $past(vld_r[NSTG-1]),
    "result appeared without an item in the last stage")
  `ASSERT_ALWAYS(a_reset_state,
    !rst_n |=> ((inv_r == INV_ONE) && !out_valid),
    "reset left register or output state")

endmodule

`default_nettype wire

// ===== test/linear_map_particle_tracker_tb.sv =====
`default_nettype none

module linear_map_particle_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmpt_pkg::*;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // One row of the directed script: a request and, where it can be read off at a
  // glance, the result it must give.
  typedef struct {
    in_item_t  req;
    bit        known;
    out_item_t res;
  } script_row_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_t;

  localparam int    LATENCY     = 10;
  localparam int    IDLE_LIMIT  = 2000;
  localparam int    RAND_ITEMS  = 180;
  localparam int    NUM_PHASES  = 6;
  localparam word_t WORD_HI     = 32'sh7FFF_FFFF;
  localparam word_t WORD_LO     = 32'sh8000_0000;
  localparam word_t ONE_Q       = 32'sh0100_0000;
  localparam longint SAT_HI     = 64'sd2147483647;
  localparam longint SAT_LO     = -64'sd2147483648;
  // Second register slot: no register lives there, so a write must change nothing.
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 1'b1;

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     psel      = 1'b0;
  logic                     penable   = 1'b0;
  logic                     pwrite    = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr     = '0;
  logic [CFG_DATA_BITS-1:0] pwdata    = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Predictor state: the map, the velocity register and the tracks still in flight.
  word_t           map_coef [NUM_COEF];
  logic [INV_BITS-1:0] inv_beta;
  out_item_t       predicted_tracks [$];

  int          mismatch_cnt = 0;
  int          burst_left   = 0;
  int          idle_cycles  = 0;
  int unsigned stall_tick   = 0;
  stall_mode_t stall_mode   = STALL_NONE;

  linear_map_particle_tracker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Exact product, rounded half up to the Q8.24 grid (arithmetic shift floors).
  function automatic longint round_mul(input longint a, input longint b);
    longint p;
    p = a * b + (longint'(1) <<< (FRAC_BITS_DEF - 1));
    return p >>> FRAC_BITS_DEF;
  endfunction

  function automatic longint clamp_word(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Push one particle through the map as it stands now.
  function automatic out_item_t track_particle(input in_item_t r);
    out_item_t o;
    longint    crd [6];
    longint    slope_vec [6];
    longint    res [6];
    longint    t;
    longint    sum;
    crd[0] = r.x_in;
    crd[1] = r.px_in;
    crd[2] = r.y_in;
    crd[3] = r.py_in;
    crd[4] = r.ct_in;
    crd[5] = r.de_in;
    if (r.lost_in) begin
      res = crd;
    end else begin
      // t = 1 - de*inv_beta, then slopes px*t and py*t, each saturated
      t = clamp_word((longint'(1) <<< FRAC_BITS_DEF)
                     - round_mul(crd[5], longint'({33'b0, inv_beta})));
      slope_vec    = crd;
      slope_vec[1] = clamp_word(round_mul(crd[1], t));
      slope_vec[3] = clamp_word(round_mul(crd[3], t));
      for (int r_i = 0; r_i < NUM_ROWS; r_i++) begin
        sum = map_coef[r_i * NUM_COL];
        for (int k = 0; k < 6; k++) begin
          // only the x and y rows see the slopes
          sum += round_mul(map_coef[r_i * NUM_COL + k + 1],
                           (r_i == 0 || r_i == 2) ? slope_vec[k] : crd[k]);
        end
        res[r_i] = clamp_word(sum);
      end
    end
    o.x_out    = word_t'(res[0]);
    o.px_out   = word_t'(res[1]);
    o.y_out    = word_t'(res[2]);
    o.py_out   = word_t'(res[3]);
    o.ct_out   = word_t'(res[4]);
    o.de_out   = word_t'(res[5]);
    o.lost_out = r.lost_in;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  // Mostly values within +-4.0, with a share of full-range words and extremes.
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return word_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return WORD_HI;
          1: return WORD_LO;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return ONE_Q;
        endcase
      end
      default: return word_t'($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
    endcase
  endfunction

  // Load request; the coordinate fields carry junk the block must ignore.
  function automatic in_item_t load_req(input int slot, input word_t val);
    in_item_t r;
    r            = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom});
    r.action     = ACT_LOAD;
    r.coef_index = IDX_BITS'(slot);
    r.coef_value = val;
    return r;
  endfunction

  // Track request; the coefficient fields carry junk.
  function automatic in_item_t track_req(input word_t x, input word_t px, input word_t y,
                                         input word_t py, input word_t ct, input word_t de,
                                         input logic lost);
    in_item_t r;
    r.action     = ACT_TRACK;
    r.coef_index = IDX_BITS'($urandom);
    r.coef_value = word_t'($urandom);
    r.x_in       = x;
    r.px_in      = px;
    r.y_in       = y;
    r.py_in      = py;
    r.ct_in      = ct;
    r.de_in      = de;
    r.lost_in    = lost;
    return r;
  endfunction

  function automatic in_item_t rand_request();
    in_item_t r;
    r = track_req(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                  rand_word(), ($urandom_range(0, 9) == 0));
    if ($urandom_range(0, 3) == 0) begin
      // one load in ten goes to a slot past the map and must be dropped
      r = load_req(($urandom_range(0, 9) == 0) ? $urandom_range(NUM_COEF, 63)
                                                : $urandom_range(0, NUM_COEF - 1),
                   rand_word());
    end
    return r;
  endfunction

  // A lost particle comes back exactly as it went in.
  function automatic out_item_t passthrough(input in_item_t r);
    return '{r.x_in, r.px_in, r.y_in, r.py_in, r.ct_in, r.de_in, r.lost_in};
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Hold a request until it is taken, then update the predictor. The sender runs in
  // bursts; insert a gap of random length between bursts.
  task automatic send_request(input in_item_t req, input bit known, input out_item_t known_res);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    if (req.action == ACT_LOAD) begin
      if (req.coef_index < NUM_COEF) map_coef[req.coef_index] = req.coef_value;
    end else begin
      predicted_tracks.push_back(known ? known_res : track_particle(req));
    end
  endtask

  // Drop valid and hold off until every predicted track has come out, then let the
  // pipeline run empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_tracks.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the data when pready is high.
  task automatic cfg_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_INV_V0BYC) inv_beta = val[INV_BITS-1:0];
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("%0t ns: %s mismatch, got %h want %h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_tracks.size() == 0) begin
        report_mismatch("unexpected result", out_data.x_out, 0);
      end else begin
        want = predicted_tracks.pop_front();
        if (out_data.x_out !== want.x_out)   report_mismatch("x_out", out_data.x_out, want.x_out);
        if (out_data.px_out !== want.px_out) report_mismatch("px_out", out_data.px_out, want.px_out);
        if (out_data.y_out !== want.y_out)   report_mismatch("y_out", out_data.y_out, want.y_out);
        if (out_data.py_out !== want.py_out) report_mismatch("py_out", out_data.py_out, want.py_out);
        if (out_data.ct_out !== want.ct_out) report_mismatch("ct_out", out_data.ct_out, want.ct_out);
        if (out_data.de_out !== want.de_out) report_mismatch("de_out", out_data.de_out, want.de_out);
        if (out_data.lost_out !== want.lost_out)
          report_mismatch("lost_out", out_data.lost_out, want.lost_out);
      end
    end

    // Switch the stall pattern each time the low six bits of stall_tick wrap to zero: none,
    // light, heavy, or long runs that fill the pipeline and push back on the input.
    stall_tick <= stall_tick + 1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick[4:0] < 5'd20);
    endcase
  end

  // Watchdog: end the run if no request and no result moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    script_row_t row;
    script_row_t script [$];
    logic [31:0] cfg_plan [NUM_PHASES];
    in_item_t    req;

    foreach (map_coef[i]) map_coef[i] = '0;
    inv_beta = INV_BITS'(ONE_Q);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero map after reset: every coordinate comes out zero, even at the extremes.
    row.req = track_req(WORD_HI, WORD_LO, -32'sd1, 32'sd1, WORD_HI, WORD_LO, 1'b0);
    row.known = 1'b1;
    row.res = '0;
    script.push_back(row);
    // Lost particle passes through unchanged.
    row.req = track_req(WORD_LO, WORD_HI, 32'sd0, -32'sd1, WORD_LO, WORD_HI, 1'b1);
    row.res = passthrough(row.req);
    script.push_back(row);
    // Loads past slot 41 are dropped, so the map stays zero.
    row.known = 1'b0;
    row.req = load_req(NUM_COEF, WORD_HI);
    script.push_back(row);
    row.req = load_req(63, WORD_LO);
    script.push_back(row);
    row.known = 1'b1;
    row.req = track_req(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1'b0);
    row.res = '0;
    script.push_back(row);
    // Identity map, the last slot (41) among them.
    row.known = 1'b0;
    for (int r_i = 0; r_i < NUM_ROWS; r_i++) begin
      row.req = load_req(r_i * NUM_COL + r_i + 1, ONE_Q);
      script.push_back(row);
    end
    row.req = track_req(32'sh0180_0000, -32'sh0040_0000, 32'sh0200_0000, 32'sh0010_0000,
                        -32'sh0300_0000, 32'sd0, 1'b0);
    script.push_back(row);
    // Most negative de drives t into saturation; so do the slopes.
    row.req = track_req(ONE_Q, WORD_HI, ONE_Q, WORD_LO, 32'sd0, WORD_LO, 1'b0);
    script.push_back(row);
    row.req = track_req(-ONE_Q, ONE_Q, 32'sh0000_1234, -ONE_Q, WORD_HI, WORD_HI, 1'b0);
    script.push_back(row);
    // Extreme coefficients so the x row sums high and the px row sums low.
    row.req = load_req(0, WORD_HI);
    script.push_back(row);
    row.req = load_req(1, WORD_HI);
    script.push_back(row);
    row.req = load_req(NUM_COL, WORD_LO);
    script.push_back(row);
    row.req = load_req(NUM_COL + 1, WORD_LO);
    script.push_back(row);
    row.req = track_req(WORD_HI, ONE_Q, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    script.push_back(row);
    // Tiny coefficient on x in the py row: products of exactly one half round up.
    row.req = load_req(3 * NUM_COL + 1, 32'sd1);
    script.push_back(row);
    row.req = track_req(32'sh0080_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    script.push_back(row);
    row.req = track_req(-32'sh0080_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    script.push_back(row);
    // A lost particle ignores a loaded map too.
    row.known = 1'b1;
    row.req = track_req(32'sh1234_5678, -32'sh0765_4321, WORD_HI, WORD_LO, 32'sd1, -32'sd1,
                        1'b1);
    row.res = passthrough(row.req);
    script.push_back(row);

    foreach (script[i]) send_request(script[i].req, script[i].known, script[i].res);
    drain();

    // Random phases, each under its own velocity setting: the maximum, a write with the
    // top bit set (dropped by the 31-bit register), below 1.0, zero, random, back to 1.0.
    cfg_plan = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0080_0000, 32'h0000_0000,
                 32'h0000_0000, 32'h0100_0000};
    cfg_plan[4] = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cfg_write(REG_INV_V0BYC, cfg_plan[ph]);
      if (ph == 2) begin
        // let the bus go idle before the next write
        @(posedge clk);
        cfg_write(REG_SPARE, $urandom);
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        req = rand_request();
        send_request(req, 1'b0, '0);
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
